// ===== hw/rtl/line_formation_pose_and_jacobian_assert.svh =====
// Assertion macros for the line formation pose and Jacobian block.
// Used by the port checker; needs nothing but the clock and reset it is given.
`ifndef LINE_FORMATION_POSE_AND_JACOBIAN_ASSERT_SVH
`define LINE_FORMATION_POSE_AND_JACOBIAN_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LFPJ_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LFPJ_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== hw/rtl/lfpj_pkg.sv =====
// Shared types, constants and helpers of the line formation block.
// No dependencies; the files that use it refer to it by scoped names.
package lfpj_pkg;

	// Number formats.
	localparam int FRAC_BITS    = 16;
	localparam int ANGLE_BITS   = 16;
	localparam int CW           = 32;              // coordinate width
	localparam int AW           = 16;              // heading and yaw field width
	localparam int PHASE_SHIFT  = 32 - ANGLE_BITS; // binary angle to 32-bit phase
	localparam int SUM_W        = CW + 1;          // centre plus offset
	localparam int PROD_W       = 2 * CW;
	localparam int SC_FRAC      = 30;              // sine and cosine fraction bits
	localparam int SC_PROD_W    = PROD_W - SC_FRAC;

	// CORDIC.
	localparam int CORDIC_STEPS = 24;
	localparam int XW           = 32;
	localparam int ZW           = 32;
	localparam logic signed [XW-1:0] CORDIC_GAIN = 32'sd652032874;
	localparam logic [31:0] EIGHTH_TURN = 32'h2000_0000;

	// arctan(2^-i), 2^32 per turn.
	localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667332,  32'sd21354465,  32'sd10679838,  32'sd5340244,
		32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
		32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
		32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
		32'sd652,       32'sd326,       32'sd163,       32'sd81
	};

	// Quadrant codes after folding.
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEADING  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPACING  = 3'd4;
	localparam logic signed [CW-1:0] UNIT_RESET   = CW'(64'sd1 <<< FRAC_BITS);

	// Saturation bounds.
	localparam logic signed [PROD_W-1:0] SAT_HI = 64'sd2147483647;
	localparam logic signed [PROD_W-1:0] SAT_LO = -64'sd2147483648;

	typedef struct packed {
		logic signed [CW-1:0] offset_x;
		logic signed [CW-1:0] offset_y;
		logic        [AW-1:0] offset_yaw;
		logic signed [CW-1:0] offset_size;
	} in_item_t;

	typedef struct packed {
		logic signed [CW-1:0] lead_x;
		logic signed [CW-1:0] lead_y;
		logic signed [CW-1:0] mid_x;
		logic signed [CW-1:0] mid_y;
		logic signed [CW-1:0] tail_x;
		logic signed [CW-1:0] tail_y;
		logic signed [CW-1:0] arm_sin;
		logic signed [CW-1:0] arm_cos;
		logic signed [CW-1:0] spacing_cos;
		logic signed [CW-1:0] spacing_sin;
		logic                 saturated;
	} result_t;

	typedef struct packed {
		logic signed [CW-1:0] centre_x;
		logic signed [CW-1:0] centre_y;
		logic        [AW-1:0] heading;
		logic signed [CW-1:0] scale;
		logic signed [CW-1:0] spacing;
	} cfg_t;

	// Data that rides alongside the CORDIC.
	typedef struct packed {
		logic        [1:0]       quad;
		logic signed [SUM_W-1:0] cx;
		logic signed [SUM_W-1:0] cy;
		logic signed [CW-1:0]    len;
		logic                    sat;
	} side_t;

	typedef struct packed {
		logic signed [CW-1:0] value;
		logic                 clip;
	} clip_t;

	// Clip a wide signed value to 32 bits and report whether it was clipped.
	function automatic clip_t sat32(input logic signed [PROD_W-1:0] v);
		clip_t r;
		if (v > SAT_HI) begin
			r.value = 32'sh7FFF_FFFF;
			r.clip  = 1'b1;
		end else if (v < SAT_LO) begin
			r.value = 32'sh8000_0000;
			r.clip  = 1'b1;
		end else begin
			r.value = v[CW-1:0];
			r.clip  = 1'b0;
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/lfpj_if.sv =====
// Stream interfaces for pose offsets in and formation results out.
// Depends on lfpj_pkg for the payload types.
interface lfpj_in_if;
	logic                 valid;
	logic                 ready;
	lfpj_pkg::in_item_t   data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lfpj_out_if;
	logic                 valid;
	logic                 ready;
	lfpj_pkg::result_t    data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/line_formation_pose_and_jacobian.sv =====
// Top level of the three-agent line formation pose and Jacobian pipeline.
// Depends on lfpj_pkg, lfpj_if, lfpj_cfg, lfpj_cordic and lfpj_skid.
//
// Usage:
//   pose takes one transaction of offsets (x, y, yaw, size) per ready cycle.
//   formation returns one transaction per pose: lead, mid and tail agent
//   positions, the four Jacobian terms and a saturation flag.
//   The config port writes centre_x, centre_y, heading, scale and spacing by
//   index; write it only while no transaction is in flight.
// Pipeline:
//   A pose's result reaches formation through three front stages (angle
//   fold and sums, spacing multiply, arm clip), 24 CORDIC stages, a
//   quadrant stage, a multiply stage and the output register.
//   One pose is taken every cycle while the output drains.
// Reset and stalls:
//   arst_n empties the pipeline and loads the registers with centre 0,
//   heading 0, scale 1.0 and spacing 1.0. When formation.ready is low the
//   output register holds and one more result lands in a skid entry; while
//   that entry is full the whole pipeline, including pose.ready, holds.
module line_formation_pose_and_jacobian (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lfpj_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lfpj_pkg::CW-1:0]           cfg_wdata,
	lfpj_in_if.sink                           pose,
	lfpj_out_if.source                        formation
);

	localparam int CW     = lfpj_pkg::CW;
	localparam int ZW     = lfpj_pkg::ZW;
	localparam int XW     = lfpj_pkg::XW;
	localparam int PW     = lfpj_pkg::PROD_W;
	localparam int SCW    = lfpj_pkg::SC_PROD_W;

	lfpj_pkg::cfg_t cfg;
	logic           en;

	lfpj_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign pose.ready = en;

	// Stage 1: angle to folded phase, size sum and centre sums.
	logic [lfpj_pkg::AW:0]  ang_sum;
	logic [31:0]            phase, fold;
	logic signed [ZW-1:0]   z_in;
	lfpj_pkg::clip_t        size_c;

	always_comb begin
		ang_sum = {1'b0, cfg.heading} + {1'b0, pose.data.offset_yaw};
		phase   = 32'(ang_sum) << lfpj_pkg::PHASE_SHIFT;
		fold    = phase + lfpj_pkg::EIGHTH_TURN;
		z_in    = $signed({2'b00, fold[29:0]}) - $signed(lfpj_pkg::EIGHTH_TURN);
		size_c  = lfpj_pkg::sat32(PW'(cfg.scale) + PW'(pose.data.offset_size));
	end

	logic                 v_s1;
	logic signed [ZW-1:0] z_s1;
	logic signed [CW-1:0] size_s1;
	lfpj_pkg::side_t      side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= pose.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1         <= z_in;
			size_s1      <= size_c.value;
			side_s1.quad <= fold[31:30];
			side_s1.cx   <= lfpj_pkg::SUM_W'(cfg.centre_x)
				+ lfpj_pkg::SUM_W'(pose.data.offset_x);
			side_s1.cy   <= lfpj_pkg::SUM_W'(cfg.centre_y)
				+ lfpj_pkg::SUM_W'(pose.data.offset_y);
			side_s1.len  <= '0;
			side_s1.sat  <= size_c.clip;
		end
	end

	// Stage 2: spacing times size.
	logic                 v_s2;
	logic signed [ZW-1:0] z_s2;
	logic signed [PW-1:0] len_prod_s2;
	lfpj_pkg::side_t      side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s2        <= z_s1;
			len_prod_s2 <= PW'(size_s1) * PW'(cfg.spacing);
			side_s2     <= side_s1;
		end
	end

	// Stage 3: rescale and clip the arm length.
	lfpj_pkg::clip_t      len_c;
	logic                 v_s3;
	logic signed [ZW-1:0] z_s3;
	lfpj_pkg::side_t      side_s3;

	assign len_c = lfpj_pkg::sat32(len_prod_s2 >>> lfpj_pkg::FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s3    <= z_s2;
			side_s3 <= '{quad: side_s2.quad, cx: side_s2.cx, cy: side_s2.cy,
				len: len_c.value, sat: side_s2.sat | len_c.clip};
		end
	end

	// CORDIC stages.
	logic                 v_cor;
	logic signed [XW-1:0] x_cor, y_cor;
	lfpj_pkg::side_t      side_cor;

	lfpj_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_z      (z_s3),
		.in_side   (side_s3),
		.out_valid (v_cor),
		.out_x     (x_cor),
		.out_y     (y_cor),
		.out_side  (side_cor)
	);

	// Quadrant stage: rotate the folded vector back by whole quarter turns.
	logic signed [XW-1:0] cos_q, sin_q;

	always_comb begin
		case (side_cor.quad)
			lfpj_pkg::QUAD_0: begin
				cos_q = x_cor;
				sin_q = y_cor;
			end
			lfpj_pkg::QUAD_1: begin
				cos_q = -y_cor;
				sin_q = x_cor;
			end
			lfpj_pkg::QUAD_2: begin
				cos_q = -x_cor;
				sin_q = -y_cor;
			end
			default: begin
				cos_q = y_cor;
				sin_q = -x_cor;
			end
		endcase
	end

	logic                 v_s28;
	logic signed [XW-1:0] cos_s28, sin_s28;
	lfpj_pkg::side_t      side_s28;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s28 <= 1'b0;
		end else if (en) begin
			v_s28 <= v_cor;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_s28  <= cos_q;
			sin_s28  <= sin_q;
			side_s28 <= side_cor;
		end
	end

	// Multiply stage: arm and spacing times sine and cosine.
	logic                 v_s29;
	logic signed [PW-1:0] lc_prod_s29, ls_prod_s29, spc_prod_s29, sps_prod_s29;
	lfpj_pkg::side_t      side_s29;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s29 <= 1'b0;
		end else if (en) begin
			v_s29 <= v_s28;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lc_prod_s29  <= PW'(side_s28.len) * PW'(cos_s28);
			ls_prod_s29  <= PW'(side_s28.len) * PW'(sin_s28);
			spc_prod_s29 <= PW'(cfg.spacing) * PW'(cos_s28);
			sps_prod_s29 <= PW'(cfg.spacing) * PW'(sin_s28);
			side_s29     <= side_s28;
		end
	end

	// Final sums and clipping feed the output register.
	logic signed [SCW-1:0] lc, ls;
	lfpj_pkg::clip_t       lead_x_c, lead_y_c, mid_x_c, mid_y_c, tail_x_c, tail_y_c;
	lfpj_pkg::clip_t       arm_sin_c, arm_cos_c, sp_cos_c, sp_sin_c;
	lfpj_pkg::result_t     result;

	always_comb begin
		lc        = SCW'(lc_prod_s29 >>> lfpj_pkg::SC_FRAC);
		ls        = SCW'(ls_prod_s29 >>> lfpj_pkg::SC_FRAC);
		lead_x_c  = lfpj_pkg::sat32(PW'(side_s29.cx) + PW'(lc));
		lead_y_c  = lfpj_pkg::sat32(PW'(side_s29.cy) + PW'(ls));
		mid_x_c   = lfpj_pkg::sat32(PW'(side_s29.cx));
		mid_y_c   = lfpj_pkg::sat32(PW'(side_s29.cy));
		tail_x_c  = lfpj_pkg::sat32(PW'(side_s29.cx) - PW'(lc));
		tail_y_c  = lfpj_pkg::sat32(PW'(side_s29.cy) - PW'(ls));
		arm_sin_c = lfpj_pkg::sat32(PW'(ls));
		arm_cos_c = lfpj_pkg::sat32(PW'(lc));
		sp_cos_c  = lfpj_pkg::sat32(spc_prod_s29 >>> lfpj_pkg::SC_FRAC);
		sp_sin_c  = lfpj_pkg::sat32(sps_prod_s29 >>> lfpj_pkg::SC_FRAC);

		result.lead_x      = lead_x_c.value;
		result.lead_y      = lead_y_c.value;
		result.mid_x       = mid_x_c.value;
		result.mid_y       = mid_y_c.value;
		result.tail_x      = tail_x_c.value;
		result.tail_y      = tail_y_c.value;
		result.arm_sin     = arm_sin_c.value;
		result.arm_cos     = arm_cos_c.value;
		result.spacing_cos = sp_cos_c.value;
		result.spacing_sin = sp_sin_c.value;
		result.saturated   = side_s29.sat
			| lead_x_c.clip | lead_y_c.clip | mid_x_c.clip | mid_y_c.clip
			| tail_x_c.clip | tail_y_c.clip | arm_sin_c.clip | arm_cos_c.clip
			| sp_cos_c.clip | sp_sin_c.clip;
	end

	lfpj_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (v_s29),
		.load_data  (result),
		.load_ready (en),
		.formation  (formation)
	);

endmodule

// ===== hw/rtl/lfpj_cfg.sv =====
// Configuration register file of the line formation block.
// Depends on lfpj_pkg for the register layout and indexes.
module lfpj_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lfpj_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lfpj_pkg::CW-1:0]           cfg_wdata,
	output lfpj_pkg::cfg_t                    cfg
);

	lfpj_pkg::cfg_t regs_q;

	// Write one register per enabled cycle; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.centre_x <= '0;
			regs_q.centre_y <= '0;
			regs_q.heading  <= '0;
			regs_q.scale    <= lfpj_pkg::UNIT_RESET;
			regs_q.spacing  <= lfpj_pkg::UNIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				lfpj_pkg::REG_CENTRE_X: regs_q.centre_x <= cfg_wdata;
				lfpj_pkg::REG_CENTRE_Y: regs_q.centre_y <= cfg_wdata;
				lfpj_pkg::REG_HEADING:  regs_q.heading  <= cfg_wdata[lfpj_pkg::AW-1:0];
				lfpj_pkg::REG_SCALE:    regs_q.scale    <= cfg_wdata;
				lfpj_pkg::REG_SPACING:  regs_q.spacing  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = regs_q;

endmodule

// ===== hw/rtl/lfpj_cordic.sv =====
// Fully unrolled CORDIC, one rotation step per pipeline stage.
// Depends on lfpj_pkg for widths, gain and the arctangent table.
module lfpj_cordic (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic signed [lfpj_pkg::ZW-1:0]      in_z,
	input  lfpj_pkg::side_t                     in_side,
	output logic                                out_valid,
	output logic signed [lfpj_pkg::XW-1:0]      out_x,
	output logic signed [lfpj_pkg::XW-1:0]      out_y,
	output lfpj_pkg::side_t                     out_side
);

	localparam int N  = lfpj_pkg::CORDIC_STEPS;
	localparam int XW = lfpj_pkg::XW;
	localparam int ZW = lfpj_pkg::ZW;

	logic                 v_s    [N];
	logic signed [XW-1:0] x_s    [N];
	logic signed [XW-1:0] y_s    [N];
	logic signed [ZW-1:0] z_s    [N];
	lfpj_pkg::side_t      side_s [N];

	for (genvar i = 0; i < N; i++) begin : g_step
		logic                 v_prev;
		logic signed [XW-1:0] x_prev, y_prev, x_next, y_next, dx, dy;
		logic signed [ZW-1:0] z_prev, z_next;
		lfpj_pkg::side_t      side_prev;

		// The first step starts from the gain-compensated unit vector.
		if (i == 0) begin : g_first
			assign v_prev    = in_valid;
			assign x_prev    = lfpj_pkg::CORDIC_GAIN;
			assign y_prev    = '0;
			assign z_prev    = in_z;
			assign side_prev = in_side;
		end else begin : g_rest
			assign v_prev    = v_s[i-1];
			assign x_prev    = x_s[i-1];
			assign y_prev    = y_s[i-1];
			assign z_prev    = z_s[i-1];
			assign side_prev = side_s[i-1];
		end

		// Rotate toward zero residual angle.
		always_comb begin
			dx = y_prev >>> i;
			dy = x_prev >>> i;
			if (!z_prev[ZW-1]) begin
				x_next = x_prev - dx;
				y_next = y_prev + dy;
				z_next = z_prev - lfpj_pkg::ATAN_TAB[i];
			end else begin
				x_next = x_prev + dx;
				y_next = y_prev - dy;
				z_next = z_prev + lfpj_pkg::ATAN_TAB[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i]    <= x_next;
				y_s[i]    <= y_next;
				z_s[i]    <= z_next;
				side_s[i] <= side_prev;
			end
		end
	end

	assign out_valid = v_s[N-1];
	assign out_x     = x_s[N-1];
	assign out_y     = y_s[N-1];
	assign out_side  = side_s[N-1];

endmodule

// ===== hw/rtl/lfpj_skid.sv =====
// Output register with a skid entry, so the pipeline stalls on a registered ready.
// Depends on lfpj_pkg and the result stream interface.
module lfpj_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load_valid,
	input  lfpj_pkg::result_t load_data,
	output logic              load_ready,
	lfpj_out_if.source        formation
);

	logic              out_v_q, skid_v_q;
	lfpj_pkg::result_t out_q, skid_q;
	logic              load_fire;

	assign load_ready = !skid_v_q;
	assign load_fire  = load_valid && load_ready;

	// Output register takes the skid entry first, then a new transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q || formation.ready) begin
				out_v_q <= skid_v_q || load_fire;
			end
			if (skid_v_q) begin
				if (formation.ready) begin
					skid_v_q <= 1'b0;
				end
			end else if (load_fire && out_v_q && !formation.ready) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || formation.ready) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (load_fire) begin
				out_q <= load_data;
			end
		end
		if (!skid_v_q && load_fire && out_v_q && !formation.ready) begin
			skid_q <= load_data;
		end
	end

	assign formation.valid = out_v_q;
	assign formation.data  = out_q;

endmodule

// ===== hw/rtl/lfpj_checker.sv =====
// Port-level checker for the line formation block, attached by bind.
// Depends on lfpj_pkg and the assertion macro header.
`include "line_formation_pose_and_jacobian_assert.svh"

module lfpj_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              pose_ready,
	input logic              formation_valid,
	input logic              formation_ready,
	input lfpj_pkg::result_t formation_data
);

	// A stalled result stays put until its transaction completes.
	`LFPJ_ASSERT_NEXT(a_out_hold, clk, arst_n, formation_valid && !formation_ready, formation_valid && $stable(formation_data), "result changed while stalled")

	// The skid entry is only full behind a held output, so an empty output means ready.
	`LFPJ_ASSERT_NOW(a_empty_ready, clk, arst_n, !formation_valid, pose_ready, "pose stalled with empty output")

	// Downstream ready always drains the skid entry, so pose is ready in the next cycle.
	`LFPJ_ASSERT_NEXT(a_drain, clk, arst_n, formation_ready, pose_ready, "pose stalled after output drained")

	// The input only stalls after the output was held back.
	`LFPJ_ASSERT_NOW(a_stall_cause, clk, arst_n, $fell(pose_ready), $past(formation_valid && !formation_ready), "pose stall without output backpressure")

endmodule

bind line_formation_pose_and_jacobian lfpj_checker u_lfpj_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.pose_ready      (pose.ready),
	.formation_valid (formation.valid),
	.formation_ready (formation.ready),
	.formation_data  (formation.data)
);

// ===== dv/tb.sv =====
// Testbench for the line formation pose and Jacobian pipeline.
// Depends on lfpj_pkg, lfpj_if and line_formation_pose_and_jacobian; self-checking
// through a scoreboard that predicts each formation transaction from the pose it follows.
`timescale 1ns / 1ps

module tb;

	localparam int CW        = lfpj_pkg::CW;
	localparam int AW        = lfpj_pkg::AW;
	localparam int CFG_IDX_W = lfpj_pkg::CFG_IDX_W;

	localparam int LATENCY      = 29;
	localparam int DRAIN_CYCLES = LATENCY + 8;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS  = 250;

	localparam logic signed [CW-1:0] WORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [CW-1:0] WORD_MIN = 32'sh8000_0000;

	// Predicts formation transactions and checks them in order of arrival.
	class formation_scoreboard;
		lfpj_pkg::cfg_t    regs;
		lfpj_pkg::result_t expected_formations[$];
		int                mismatch_count;
		bit                clipped;

		function new();
			regs.centre_x  = '0;
			regs.centre_y  = '0;
			regs.heading   = '0;
			regs.scale     = lfpj_pkg::UNIT_RESET;
			regs.spacing   = lfpj_pkg::UNIT_RESET;
			mismatch_count = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] value);
			case (idx)
				lfpj_pkg::REG_CENTRE_X: regs.centre_x = value;
				lfpj_pkg::REG_CENTRE_Y: regs.centre_y = value;
				lfpj_pkg::REG_HEADING:  regs.heading  = value[AW-1:0];
				lfpj_pkg::REG_SCALE:    regs.scale    = value;
				lfpj_pkg::REG_SPACING:  regs.spacing  = value;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_formations.size();
		endfunction

		// Clip to a signed 32-bit word and remember that it happened.
		function longint clip_word(longint v);
			if (v > longint'(WORD_MAX)) begin
				clipped = 1'b1;
				return longint'(WORD_MAX);
			end
			if (v < longint'(WORD_MIN)) begin
				clipped = 1'b1;
				return longint'(WORD_MIN);
			end
			return v;
		endfunction

		// Fold into the eighth turn around zero, rotate, then unfold the quadrant.
		function void sin_cos(input logic [31:0] phase, output longint s, output longint c);
			logic [31:0] t;
			logic [1:0]  quad;
			longint      x, y, z, dx, dy;
			int          i;
			t    = phase + lfpj_pkg::EIGHTH_TURN;
			quad = t[31:30];
			z    = longint'({2'b00, t[29:0]}) - longint'(lfpj_pkg::EIGHTH_TURN);
			x    = longint'(lfpj_pkg::CORDIC_GAIN);
			y    = 0;
			for (i = 0; i < lfpj_pkg::CORDIC_STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x = x - dx;
					y = y + dy;
					z = z - longint'(lfpj_pkg::ATAN_TAB[i]);
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + longint'(lfpj_pkg::ATAN_TAB[i]);
				end
			end
			case (quad)
				lfpj_pkg::QUAD_0: begin c = x;  s = y;  end
				lfpj_pkg::QUAD_1: begin c = -y; s = x;  end
				lfpj_pkg::QUAD_2: begin c = -x; s = -y; end
				default: begin c = y; s = -x; end
			endcase
		endfunction

		function lfpj_pkg::result_t predict_formation(lfpj_pkg::in_item_t p);
			lfpj_pkg::result_t r;
			logic [AW-1:0]     ang;
			logic [31:0]       phase;
			longint            s, c, sp, size, len, lc, ls, cx, cy;
			clipped = 1'b0;
			ang     = regs.heading + p.offset_yaw;
			phase   = 32'(ang) << lfpj_pkg::PHASE_SHIFT;
			sin_cos(phase, s, c);
			sp   = longint'($signed(regs.spacing));
			size = clip_word(longint'($signed(regs.scale)) + longint'($signed(p.offset_size)));
			len  = clip_word((sp * size) >>> lfpj_pkg::FRAC_BITS);
			lc   = (len * c) >>> lfpj_pkg::SC_FRAC;
			ls   = (len * s) >>> lfpj_pkg::SC_FRAC;
			cx   = longint'($signed(regs.centre_x)) + longint'($signed(p.offset_x));
			cy   = longint'($signed(regs.centre_y)) + longint'($signed(p.offset_y));
			r.lead_x      = CW'(clip_word(cx + lc));
			r.lead_y      = CW'(clip_word(cy + ls));
			r.mid_x       = CW'(clip_word(cx));
			r.mid_y       = CW'(clip_word(cy));
			r.tail_x      = CW'(clip_word(cx - lc));
			r.tail_y      = CW'(clip_word(cy - ls));
			r.arm_sin     = CW'(clip_word(ls));
			r.arm_cos     = CW'(clip_word(lc));
			r.spacing_cos = CW'(clip_word((sp * c) >>> lfpj_pkg::SC_FRAC));
			r.spacing_sin = CW'(clip_word((sp * s) >>> lfpj_pkg::SC_FRAC));
			r.saturated   = clipped;
			return r;
		endfunction

		function void note_pose(lfpj_pkg::in_item_t p);
			expected_formations.push_back(predict_formation(p));
		endfunction

		task report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
			$display("[%0t] formation mismatch on %s: got %h, want %h", $time, what, got, want);
			mismatch_count++;
		endtask

		task compare_field(string what, logic [CW-1:0] got, logic [CW-1:0] want);
			if (got !== want)
				report_mismatch(what, got, want);
		endtask

		task check_result(lfpj_pkg::result_t got);
			lfpj_pkg::result_t want;
			if (expected_formations.size() == 0) begin
				report_mismatch("unexpected transaction", got.lead_x, 'x);
				return;
			end
			want = expected_formations.pop_front();
			compare_field("lead_x", got.lead_x, want.lead_x);
			compare_field("lead_y", got.lead_y, want.lead_y);
			compare_field("mid_x", got.mid_x, want.mid_x);
			compare_field("mid_y", got.mid_y, want.mid_y);
			compare_field("tail_x", got.tail_x, want.tail_x);
			compare_field("tail_y", got.tail_y, want.tail_y);
			compare_field("arm_sin", got.arm_sin, want.arm_sin);
			compare_field("arm_cos", got.arm_cos, want.arm_cos);
			compare_field("spacing_cos", got.spacing_cos, want.spacing_cos);
			compare_field("spacing_sin", got.spacing_sin, want.spacing_sin);
			compare_field("saturated", 32'(got.saturated), 32'(want.saturated));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CW-1:0]        cfg_wdata;

	lfpj_in_if  pose_if ();
	lfpj_out_if formation_if ();

	formation_scoreboard sb;
	bit steady;
	int cycle_count;

	line_formation_pose_and_jacobian u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pose      (pose_if),
		.formation (formation_if)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog on the total run length.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int unsigned pick;
		if (steady)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		if (pick < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [CW-1:0] rand_coord();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0: return WORD_MAX;
			1: return WORD_MIN;
			2, 3, 4: return $urandom;
			default: return 32'($urandom_range(0, 32'h20_0000)) - 32'h10_0000;
		endcase
	endfunction

	// Size and spacing factors: mostly a few units either way, sometimes anything.
	function automatic logic [CW-1:0] rand_factor();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0: return WORD_MAX;
			1: return WORD_MIN;
			2, 3: return $urandom;
			default: return 32'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
		endcase
	endfunction

	// Angles: quadrant and octant boundaries now and then, else anything.
	function automatic logic [AW-1:0] rand_angle();
		if ($urandom_range(0, 9) < 2)
			return {3'($urandom_range(0, 7)), 13'b0};
		return 16'($urandom);
	endfunction

	function automatic lfpj_pkg::in_item_t make_pose(logic [CW-1:0] x, logic [CW-1:0] y,
			logic [AW-1:0] yaw, logic [CW-1:0] size);
		lfpj_pkg::in_item_t p;
		p.offset_x    = x;
		p.offset_y    = y;
		p.offset_yaw  = yaw;
		p.offset_size = size;
		return p;
	endfunction

	function automatic lfpj_pkg::cfg_t make_regs(logic [CW-1:0] cx, logic [CW-1:0] cy,
			logic [AW-1:0] hd, logic [CW-1:0] sc, logic [CW-1:0] sp);
		lfpj_pkg::cfg_t c;
		c.centre_x = cx;
		c.centre_y = cy;
		c.heading  = hd;
		c.scale    = sc;
		c.spacing  = sp;
		return c;
	endfunction

	// One register write; the enable is left high for a following write.
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		sb.set_register(idx, value);
	endtask

	// Write all five registers, then poke the unused indexes, which must be ignored.
	task automatic program_registers(lfpj_pkg::cfg_t c);
		int idx;
		write_register(lfpj_pkg::REG_CENTRE_X, c.centre_x);
		write_register(lfpj_pkg::REG_CENTRE_Y, c.centre_y);
		write_register(lfpj_pkg::REG_HEADING, CW'(c.heading));
		write_register(lfpj_pkg::REG_SCALE, c.scale);
		write_register(lfpj_pkg::REG_SPACING, c.spacing);
		for (idx = int'(lfpj_pkg::REG_SPACING) + 1; idx < (1 << CFG_IDX_W); idx++)
			write_register(CFG_IDX_W'(idx), $urandom);
		cfg_we <= 1'b0;
	endtask

	// Hold off the sender until every expected transaction has come back.
	task automatic wait_drained();
		pose_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Offer one pose after a random gap and wait until it is accepted.
	task automatic send_pose(lfpj_pkg::in_item_t p);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			pose_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pose_if.valid <= 1'b1;
		pose_if.data  <= p;
		@(posedge clk);
		while (!pose_if.ready)
			@(posedge clk);
		sb.note_pose(p);
	endtask

	task automatic run_random(int count, bit pause_midway);
		int n;
		for (n = 0; n < count; n++) begin
			if (pause_midway && n == count / 2)
				wait_drained();
			send_pose(make_pose(rand_coord(), rand_coord(), rand_angle(), rand_factor()));
		end
	endtask

	// Result side: check each accepted transaction, stall at random.
	initial begin
		int stall_left;
		stall_left = 0;
		formation_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && formation_if.valid && formation_if.ready)
				sb.check_result(formation_if.data);
			if (steady)
				stall_left = 0;
			else if (stall_left == 0 && $urandom_range(0, 99) < 15)
				stall_left = pick_gap();
			if (stall_left > 0) begin
				formation_if.ready <= 1'b0;
				stall_left--;
			end else begin
				formation_if.ready <= 1'b1;
			end
		end
	end

	// Main sequence.
	initial begin
		int ph;
		sb = new();
		steady = 1'b0;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= '0;
		cfg_wdata     <= '0;
		pose_if.valid <= 1'b0;
		pose_if.data  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: angle sweep, position and size overflow, negative size.
		send_pose(make_pose('0, '0, 16'h0000, '0));
		send_pose(make_pose('0, '0, 16'h2000, '0));
		send_pose(make_pose('0, '0, 16'h4000, '0));
		send_pose(make_pose('0, '0, 16'h6000, '0));
		send_pose(make_pose('0, '0, 16'h8000, '0));
		send_pose(make_pose('0, '0, 16'hC000, '0));
		send_pose(make_pose('0, '0, 16'hFFFF, '0));
		send_pose(make_pose(WORD_MAX, WORD_MAX, 16'h1234, '0));
		send_pose(make_pose(WORD_MIN, WORD_MIN, 16'h8000, '0));
		send_pose(make_pose('0, '0, 16'h0000, WORD_MAX));
		send_pose(make_pose('0, '0, 16'h0000, WORD_MIN));
		send_pose(make_pose('0, '0, 16'h4000, -lfpj_pkg::UNIT_RESET));

		// Extreme settings: arm length clips, heading wraps with the yaw offset.
		wait_drained();
		program_registers(make_regs(WORD_MAX, WORD_MIN, 16'hFFFF, WORD_MIN, WORD_MAX));
		send_pose(make_pose('0, '0, 16'h0001, '0));
		send_pose(make_pose('0, '0, 16'h8001, '0));
		send_pose(make_pose(WORD_MAX, WORD_MIN, 16'h4001, '0));
		send_pose(make_pose(WORD_MIN, WORD_MAX, 16'hC001, WORD_MAX));

		// Opposite extremes: negative spacing flips the line, Jacobian terms may clip.
		wait_drained();
		program_registers(make_regs(WORD_MIN, WORD_MAX, 16'h0000, WORD_MAX, WORD_MIN));
		send_pose(make_pose('0, '0, 16'h8000, '0));
		send_pose(make_pose('0, '0, 16'h0000, '0));
		send_pose(make_pose(WORD_MAX, WORD_MAX, 16'hFFFF, WORD_MIN));
		send_pose(make_pose(WORD_MIN, WORD_MIN, 16'h2000, 32'd1));

		// Random settings per phase; one phase at full rate, one with a mid-phase drain.
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_drained();
			program_registers(make_regs(rand_coord(), rand_coord(), rand_angle(),
				rand_factor(), rand_factor()));
			steady = (ph == 2);
			run_random(PHASE_ITEMS, ph == 3);
		end
		steady = 1'b0;

		wait_drained();
		if (sb.mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/lfpj_pkg.sv
hw/rtl/lfpj_if.sv
hw/rtl/lfpj_cfg.sv
hw/rtl/lfpj_cordic.sv
hw/rtl/lfpj_skid.sv
hw/rtl/line_formation_pose_and_jacobian.sv
hw/rtl/lfpj_checker.sv
dv/tb.sv
